@@ rtl/assert_macros.svh @@
// Assertion helpers, compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define SRQ_ASSERT(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("srq: check failed");

`define SRQ_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("srq: implication failed");

`define SRQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("srq: next-cycle check failed");

`else

`define SRQ_ASSERT(label, clk, rst, expr)
`define SRQ_ASSERT_IMP(label, clk, rst, ante, cons)
`define SRQ_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ rtl/srq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package srq_pkg;

  localparam int DEPTH = 64;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int HW    = 32;
  localparam int PW    = 16;

  typedef enum logic [2:0] {
    OP_ENQ   = 3'd0,
    OP_DEQ   = 3'd1,
    OP_PEEK  = 3'd2,
    OP_DEL   = 3'd3,
    OP_SRCH  = 3'd4,
    OP_FETCH = 3'd5,
    OP_CLR   = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_NULL  = 2'd3
  } status_t;

  // Classified command: null-handle and unknown cases resolved up front.
  typedef enum logic [3:0] {
    K_ENQ,
    K_DEQ,
    K_PEEK,
    K_DEL,
    K_SRCH,
    K_FETCH,
    K_CLR,
    K_NULL,
    K_MISS
  } kind_t;

  typedef struct packed {
    kind_t         kind;
    logic [HW-1:0] handle;
    logic [PW-1:0] pid;
  } cmd_t;

endpackage

`default_nettype wire

@@ rtl/searchable_ring_queue.sv @@
// Channel | Handshake           | Payload
// in      | in_valid, in_stall  | operation, handle, pid
// out     | out_valid, out_stall| status, handle_out, pid_out, slot, count_out
//
// Enqueue, clear and rejected items go from idle to done; dequeue and peek pass through read first.
// Search and fetch: entries compared one per cycle from the head.
// Delete: a compare walk, then a shift where needed; the compare walk and the shift share one memory read port.
// Reset clears head, count, the back-end state and out_valid; slot storage is not cleared.
// A two-item command queue takes input while the back end works; the output register
// lets the back end start the next item while a result is held by out_stall.
`timescale 1ns / 1ps
`default_nettype none

module searchable_ring_queue (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [2:0]             operation,
  input  wire logic [srq_pkg::HW-1:0] handle,
  input  wire logic [srq_pkg::PW-1:0] pid,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [1:0]                  status,
  output logic [srq_pkg::HW-1:0]      handle_out,
  output logic [srq_pkg::PW-1:0]      pid_out,
  output logic [srq_pkg::AW-1:0]      slot,
  output logic [srq_pkg::CW-1:0]      count_out
);
  import srq_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_take;

  srq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .handle    (handle),
    .pid       (pid),
    .cmd_valid (cmd_valid),
    .cmd_out   (cmd),
    .cmd_take  (cmd_take)
  );

  srq_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_in     (cmd),
    .cmd_take   (cmd_take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .handle_out (handle_out),
    .pid_out    (pid_out),
    .slot       (slot),
    .count_out  (count_out)
  );

endmodule

`default_nettype wire

@@ rtl/srq_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module srq_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [2:0]            operation,
  input  wire logic [srq_pkg::HW-1:0] handle,
  input  wire logic [srq_pkg::PW-1:0] pid,
  output logic                       cmd_valid,
  output srq_pkg::cmd_t              cmd_out,
  input  wire logic                  cmd_take
);
  import srq_pkg::*;

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] q_cnt;
  logic       push;
  cmd_t       cls;
  logic       is_null;

  assign in_stall  = (q_cnt == 2'd2);
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (q_cnt != 2'd0);
  assign cmd_out   = q[rd_ptr];
  assign is_null   = (handle == '0);

  always_comb begin
    cls.handle = handle;
    cls.pid    = pid;
    unique case (operation)
      OP_ENQ:   cls.kind = is_null ? K_NULL : K_ENQ;
      OP_DEQ:   cls.kind = K_DEQ;
      OP_PEEK:  cls.kind = K_PEEK;
      OP_DEL:   cls.kind = is_null ? K_NULL : K_DEL;
      OP_SRCH:  cls.kind = is_null ? K_MISS : K_SRCH;
      OP_FETCH: cls.kind = K_FETCH;
      OP_CLR:   cls.kind = K_CLR;
      default:  cls.kind = K_MISS;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      q_cnt  <= 2'd0;
    end else begin
      if (push) begin
        q[wr_ptr] <= cls;
        wr_ptr    <= ~wr_ptr;
      end
      if (cmd_take) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !cmd_take) begin
        q_cnt <= q_cnt + 2'd1;
      end else if (!push && cmd_take) begin
        q_cnt <= q_cnt - 2'd1;
      end
    end
  end

`include "assert_macros.svh"

  `SRQ_ASSERT(a_cnt_bound, clk, rst, q_cnt <= 2'd2)
  `SRQ_ASSERT_IMP(a_pop_nonempty, clk, rst, cmd_take, q_cnt != 2'd0)
  `SRQ_ASSERT_NEXT(a_push_grows, clk, rst, push && !cmd_take, q_cnt == $past(q_cnt) + 2'd1)

endmodule

`default_nettype wire

@@ rtl/srq_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module srq_back (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cmd_valid,
  input  wire srq_pkg::cmd_t          cmd_in,
  output logic                        cmd_take,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [1:0]                  status,
  output logic [srq_pkg::HW-1:0]      handle_out,
  output logic [srq_pkg::PW-1:0]      pid_out,
  output logic [srq_pkg::AW-1:0]      slot,
  output logic [srq_pkg::CW-1:0]      count_out
);
  import srq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                         input logic [CW:0]   logical);
    logic [CW+1:0] sum;
    sum = (CW+2)'(base) + (CW+2)'(logical);
    if (sum >= (CW+2)'(DEPTH)) begin
      sum = sum - (CW+2)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  logic [HW-1:0] mem_h [DEPTH];
  logic [PW-1:0] mem_p [DEPTH];
  logic [HW-1:0] rd_h;
  logic [PW-1:0] rd_p;

  state_t        state;
  logic [AW-1:0] head;
  logic [CW-1:0] count;
  cmd_t          cmd;
  logic [CW-1:0] idx;
  status_t       pend_status;
  logic [HW-1:0] pend_h;
  logic [PW-1:0] pend_p;
  logic [AW-1:0] pend_slot;

  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [HW-1:0] wr_h;
  logic [PW-1:0] wr_p;
  logic [CW:0]   idx_p1;
  logic [CW:0]   idx_p2;
  logic [AW-1:0] head_inc;
  logic          hit;
  logic          last;
  logic          out_free;
  logic          full;

  assign idx_p1   = {1'b0, idx} + (CW+1)'(1);
  assign idx_p2   = {1'b0, idx} + (CW+1)'(2);
  assign head_inc = (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);
  assign hit      = (cmd.kind == K_FETCH) ? (rd_p == cmd.pid) : (rd_h == cmd.handle);
  assign last     = (idx_p1 == {1'b0, count});
  assign out_free = !out_valid || !out_stall;
  assign full     = (count == CW'(DEPTH));
  assign cmd_take = (state == S_IDLE) && cmd_valid;

  always_comb begin
    unique case (state)
      S_SCAN:  rd_addr = phys(head, idx_p1);
      S_SHIFT: rd_addr = phys(head, idx_p2);
      default: rd_addr = head;
    endcase
  end

  always_comb begin
    if (state == S_SHIFT) begin
      wr_en   = 1'b1;
      wr_addr = phys(head, {1'b0, idx});
      wr_h    = rd_h;
      wr_p    = rd_p;
    end else begin
      wr_en   = cmd_take && (cmd_in.kind == K_ENQ) && !full;
      wr_addr = phys(head, {1'b0, count});
      wr_h    = cmd_in.handle;
      wr_p    = cmd_in.pid;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_h[wr_addr] <= wr_h;
      mem_p[wr_addr] <= wr_p;
    end
    rd_h <= mem_h[rd_addr];
    rd_p <= mem_p[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd       <= cmd_in;
            idx       <= '0;
            pend_h    <= '0;
            pend_p    <= '0;
            pend_slot <= '0;
            unique case (cmd_in.kind)
              K_ENQ: begin
                state <= S_DONE;
                if (full) begin
                  pend_status <= ST_FULL;
                end else begin
                  pend_status <= ST_OK;
                  count       <= count + CW'(1);
                end
              end
              K_DEQ, K_PEEK: begin
                if (count == '0) begin
                  pend_status <= ST_EMPTY;
                  state       <= S_DONE;
                end else begin
                  pend_status <= ST_OK;
                  state       <= S_READ;
                end
              end
              K_DEL, K_SRCH, K_FETCH: begin
                if (count == '0) begin
                  pend_status <= ST_EMPTY;
                  state       <= S_DONE;
                end else begin
                  pend_status <= ST_OK;
                  state       <= S_SCAN;
                end
              end
              K_CLR: begin
                head        <= '0;
                count       <= '0;
                pend_status <= ST_OK;
                state       <= S_DONE;
              end
              K_NULL: begin
                pend_status <= ST_NULL;
                state       <= S_DONE;
              end
              default: begin
                pend_status <= ST_EMPTY;
                state       <= S_DONE;
              end
            endcase
          end
        end
        S_READ: begin
          pend_h <= rd_h;
          pend_p <= rd_p;
          if (cmd.kind == K_DEQ) begin
            head  <= head_inc;
            count <= count - CW'(1);
          end
          state <= S_DONE;
        end
        S_SCAN: begin
          if (hit) begin
            unique case (cmd.kind)
              K_SRCH: begin
                pend_slot <= phys(head, {1'b0, idx});
                state     <= S_DONE;
              end
              K_FETCH: begin
                pend_h <= rd_h;
                pend_p <= rd_p;
                state  <= S_DONE;
              end
              default: begin
                if (idx == '0) begin
                  head  <= head_inc;
                  count <= count - CW'(1);
                  state <= S_DONE;
                end else if (last) begin
                  count <= count - CW'(1);
                  state <= S_DONE;
                end else begin
                  state <= S_SHIFT;
                end
              end
            endcase
          end else if (last) begin
            pend_status <= ST_EMPTY;
            state       <= S_DONE;
          end else begin
            idx <= idx + CW'(1);
          end
        end
        S_SHIFT: begin
          idx <= idx + CW'(1);
          if (idx_p2 == {1'b0, count}) begin
            count <= count - CW'(1);
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            status     <= pend_status;
            handle_out <= pend_h;
            pid_out    <= pend_p;
            slot       <= pend_slot;
            count_out  <= count;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`include "assert_macros.svh"

  `SRQ_ASSERT(a_count_bound, clk, rst, count <= CW'(DEPTH))
  `SRQ_ASSERT_IMP(a_shift_is_del, clk, rst, state == S_SHIFT, cmd.kind == K_DEL)
  `SRQ_ASSERT_IMP(a_scan_in_window, clk, rst, state == S_SCAN, idx < count)
  `SRQ_ASSERT_IMP(a_out_from_done, clk, rst, $rose(out_valid), $past(state) == S_DONE)

endmodule

`default_nettype wire
